// ===== sv/acmp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmp_pkg
// Shared types and codes for the amplifier control message parser.
// ----------------------------------------------------------------------------
package acmp_pkg;

    // Status bytes that open a message
    localparam logic [7:0] StatusReset       = 8'hBF;
    localparam logic [7:0] StatusProgram     = 8'hC0;
    localparam logic [7:0] StatusStomp       = 8'hB0;
    localparam logic [7:0] StatusTuner       = 8'hA0;
    localparam logic [7:0] StatusTunerSilent = 8'hD0;
    localparam logic [7:0] StatusDelay       = 8'hE0;

    // First data byte values that qualify a message
    localparam logic [7:0] CtrlReset       = 8'h79;
    localparam logic [7:0] CtrlStomp       = 8'h5F;
    localparam logic [7:0] CtrlTunerSilent = 8'h7F;
    localparam logic [7:0] CtrlTunerOnOff  = 8'h00;

    typedef enum logic [2:0] {
        EV_RESET        = 3'd0,
        EV_PROGRAM      = 3'd1,
        EV_STOMP        = 3'd2,
        EV_TUNER_ONOFF  = 3'd3,
        EV_TUNER_VALUE  = 3'd4,
        EV_TUNER_SILENT = 3'd5,
        EV_DELAY        = 3'd6
    } event_kind_t;

    typedef struct packed {
        event_kind_t event_kind;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic        pedal_on;
        logic        modulation_on;
        logic        delay_on;
        logic        reverb_on;
        logic [15:0] delay_time_ms;
    } result_t;

    // Total message length in bytes, status included; 0 for a non-status byte
    function automatic logic [1:0] msg_length(input logic [7:0] b);
        logic [1:0] len;
        case (b) inside
            StatusProgram, StatusTunerSilent:                   len = 2'd2;
            StatusReset, StatusStomp, StatusTuner, StatusDelay: len = 2'd3;
            default:                                            len = 2'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== sv/amp_control_message_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amp_control_message_parser_unit
// Parses status-byte control messages from a serial byte stream and emits
// at most one decoded event per completed message.
// ----------------------------------------------------------------------------
//  channel   dir  ports                                         transaction
//  s_*       in   s_valid, s_ready, s_rx_byte                   one rx byte
//  m_*       out  m_valid, m_ready, m_event_kind ... m_delay_*  one event
//
//  One byte per cycle while s_ready is high; a byte is decoded in the cycle
//  it is accepted; its event, if any, is registered in out_reg or skid_reg.
//  A two-entry output stage (output register plus skid) lets one further event
//  wait while m_ready is low; s_ready drops only while the skid is full.
//  aresetn (synchronous, active low) returns the parser to idle, no event.
// ----------------------------------------------------------------------------
module amp_control_message_parser_unit (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_rx_byte,
    output logic                     m_valid,
    input  logic                     m_ready,
    output acmp_pkg::event_kind_t    m_event_kind,
    output logic [7:0]               m_first_data,
    output logic [7:0]               m_second_data,
    output logic                     m_pedal_on,
    output logic                     m_modulation_on,
    output logic                     m_delay_on,
    output logic                     m_reverb_on,
    output logic [15:0]              m_delay_time_ms
);
    import acmp_pkg::*;

    logic [7:0] status_reg;
    logic [7:0] data0_reg;
    logic [1:0] count_reg, count_next;
    logic [7:0] status_next;

    result_t out_reg, skid_reg, ev;
    logic    out_valid_reg, skid_valid_reg;
    logic    ev_valid;

    logic       s_fire, out_fire, completing;
    logic [7:0] d1, d2;
    logic [1:0] cur_len;

    assign s_ready  = !skid_valid_reg;
    assign s_fire   = s_valid && s_ready;
    assign out_fire = out_valid_reg && m_ready;

    // ---------------- message tracking ----------------
    assign cur_len    = msg_length(status_reg);
    assign completing = (count_reg != 2'd0) && ((count_reg + 2'd1) == cur_len);

    // d1: byte just taken if it is the first data byte, else the stored one
    assign d1 = (count_reg == 2'd1) ? s_rx_byte : data0_reg;
    assign d2 = s_rx_byte;

    always_comb begin
        status_next = status_reg;
        count_next  = count_reg;
        if (count_reg == 2'd0) begin
            if (msg_length(s_rx_byte) != 2'd0) begin
                status_next = s_rx_byte;
                count_next  = 2'd1;
            end
        end else if (completing) begin
            count_next = 2'd0;
        end else begin
            count_next = count_reg + 2'd1;
        end
    end

    // ---------------- event decode ----------------
    always_comb begin
        ev       = '0;
        ev_valid = 1'b0;
        if (completing) begin
            case (status_reg)
                StatusReset: begin
                    ev.event_kind = EV_RESET;
                    ev_valid      = (d1 == CtrlReset);
                end
                StatusProgram: begin
                    ev.event_kind = EV_PROGRAM;
                    ev.first_data = d1;
                    ev_valid      = 1'b1;
                end
                StatusStomp: begin
                    ev.event_kind    = EV_STOMP;
                    ev.pedal_on      = d2[0];
                    ev.modulation_on = d2[1];
                    ev.delay_on      = d2[2];
                    ev.reverb_on     = d2[3];
                    ev_valid         = (d1 == CtrlStomp);
                end
                StatusTuner: begin
                    ev.second_data = d2;
                    ev_valid       = 1'b1;
                    if (d1 == CtrlTunerOnOff) begin
                        ev.event_kind = EV_TUNER_ONOFF;
                    end else begin
                        ev.event_kind = EV_TUNER_VALUE;
                        ev.first_data = d1;
                    end
                end
                StatusTunerSilent: begin
                    ev.event_kind = EV_TUNER_SILENT;
                    ev_valid      = (d1 == CtrlTunerSilent);
                end
                StatusDelay: begin
                    ev.event_kind    = EV_DELAY;
                    ev.delay_time_ms = {1'b0, d2, 7'd0} + {8'd0, d1};
                    ev_valid         = 1'b1;
                end
                default: begin
                    ev_valid = 1'b0;
                end
            endcase
        end
    end

    // ---------------- state and output stage ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg     <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                status_reg <= status_next;
                count_reg  <= count_next;
                if (count_reg == 2'd1) begin
                    data0_reg <= s_rx_byte;
                end
            end

            if (!out_valid_reg || out_fire) begin
                if (skid_valid_reg) begin
                    out_reg        <= skid_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else if (s_fire && ev_valid) begin
                    out_reg       <= ev;
                    out_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end else if (s_fire && ev_valid) begin
                // output stalled: park the new event
                skid_reg       <= ev;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_event_kind    = out_reg.event_kind;
    assign m_first_data    = out_reg.first_data;
    assign m_second_data   = out_reg.second_data;
    assign m_pedal_on      = out_reg.pedal_on;
    assign m_modulation_on = out_reg.modulation_on;
    assign m_delay_on      = out_reg.delay_on;
    assign m_reverb_on     = out_reg.reverb_on;
    assign m_delay_time_ms = out_reg.delay_time_ms;

    // ---------------- assertions ----------------
    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an event while output register is empty");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("byte count out of range");

    a_idle_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && count_reg == 2'd0 && msg_length(s_rx_byte) == 2'd0)
        |=> (count_reg == 2'd0) && $stable(status_reg))
        else $error("non-status byte started a message");

    a_stomp_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.event_kind != EV_STOMP)
        |-> !(out_reg.pedal_on || out_reg.modulation_on
              || out_reg.delay_on || out_reg.reverb_on))
        else $error("stomp flags set on a non-stomp event");

    a_event_on_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !completing && !skid_valid_reg && !out_fire && !out_valid_reg)
        |=> !out_valid_reg)
        else $error("event emitted without a completed message");

endmodule
